// ===== sv/bmjs_pkg.sv =====
package bmjs_pkg;

  // Command codes carried in the cmd field of an item
  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_STOP   = 3'd1,
    CMD_PAUSE  = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_RESET  = 3'd4,
    CMD_SIGHT  = 3'd5,
    CMD_SPEED  = 3'd6,
    CMD_TICK   = 3'd7
  } cmd_e;

  // Belt mode; the status code for jammed is reported separately
  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_e;

  localparam logic [1:0] STATUS_JAMMED = 2'd3;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOW_SPEED_LIMIT = 2'd0,
    CFG_JAM_TICKS       = 2'd1,
    CFG_HOLDOFF_TICKS   = 2'd2,
    CFG_COOLDOWN_TICKS  = 2'd3
  } cfg_idx_e;

  localparam int unsigned CntW  = 16;
  localparam int unsigned ColorW = 4;

  localparam logic [CntW-1:0] CNT_MAX = '1;

  // Configuration reset values
  localparam logic [15:0] LOW_SPEED_LIMIT_RST = 16'd38;
  localparam logic [15:0] JAM_TICKS_RST       = 16'd50;
  localparam logic [15:0] HOLDOFF_TICKS_RST   = 16'd350;
  localparam logic [15:0] COOLDOWN_TICKS_RST  = 16'd20;

  typedef struct packed {
    logic [15:0]     low_speed_limit;  // signed Q8.8
    logic [CntW-1:0] jam_ticks;
    logic [CntW-1:0] holdoff_ticks;
    logic [CntW-1:0] cooldown_ticks;
  } cfg_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [15:0]       speed_sample;  // signed Q8.8
    logic [ColorW-1:0] color_code;
    logic              near_gate;
  } item_t;

  typedef struct packed {
    logic [1:0]        mode_status;
    logic              drive_enable;
    logic              sort_fire;
    logic [ColorW-1:0] sort_color;
    logic              jam_event;
    logic [CntW-1:0]   low_duration;
  } result_t;

  typedef struct packed {
    mode_e             mode;
    logic              jam;
    logic [CntW-1:0]   low_cnt;
    logic [CntW-1:0]   uptime_cnt;
    logic [CntW-1:0]   since_sort_cnt;
    logic [15:0]       speed;  // signed Q8.8
    logic [ColorW-1:0] seen_color;
    logic [ColorW-1:0] sorted_color;
    logic              gate;
  } state_t;

  localparam state_t STATE_RST = '{
    mode:           MODE_STOPPED,
    jam:            1'b0,
    low_cnt:        '0,
    uptime_cnt:     '0,
    since_sort_cnt: '0,
    speed:          '0,
    seen_color:     '0,
    sorted_color:   '0,
    gate:           1'b0
  };

  // Saturating increment for tick counters
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== sv/bmjs_in_if.sv =====
interface bmjs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] speed_sample;
  logic [3:0]  color_code;
  logic        near_gate;

  modport source (
    output valid, cmd, speed_sample, color_code, near_gate,
    input  ready
  );

  modport sink (
    input  valid, cmd, speed_sample, color_code, near_gate,
    output ready
  );
endinterface

// ===== sv/bmjs_out_if.sv =====
interface bmjs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode_status;
  logic        drive_enable;
  logic        sort_fire;
  logic [3:0]  sort_color;
  logic        jam_event;
  logic [15:0] low_duration;

  modport source (
    output valid, mode_status, drive_enable, sort_fire, sort_color, jam_event,
           low_duration,
    input  ready
  );

  modport sink (
    input  valid, mode_status, drive_enable, sort_fire, sort_color, jam_event,
           low_duration,
    output ready
  );
endinterface

// ===== sv/bmjs_step.sv =====
// Next-state and result logic for one item
module bmjs_step (
  input  bmjs_pkg::state_t  state_i,
  input  bmjs_pkg::cfg_t    cfg_i,
  input  bmjs_pkg::item_t   item_i,
  output bmjs_pkg::state_t  state_o,
  output bmjs_pkg::result_t result_o
);

  bmjs_pkg::state_t              ns;
  logic                          drive;
  logic                          fire;
  logic                          alert;
  logic [bmjs_pkg::ColorW-1:0]   fire_color;

  always_comb begin
    ns         = state_i;
    fire       = 1'b0;
    alert      = 1'b0;
    fire_color = '0;

    // Mode commands, sightings and speed samples
    unique case (item_i.cmd)
      bmjs_pkg::CMD_START: begin
        if (state_i.mode == bmjs_pkg::MODE_STOPPED) begin
          ns.mode    = bmjs_pkg::MODE_RUNNING;
          ns.low_cnt = '0;
          ns.jam     = 1'b0;
        end
      end
      bmjs_pkg::CMD_STOP: begin
        if (state_i.mode == bmjs_pkg::MODE_RUNNING ||
            state_i.mode == bmjs_pkg::MODE_PAUSED) begin
          ns.mode    = bmjs_pkg::MODE_STOPPED;
          ns.low_cnt = '0;
        end
      end
      bmjs_pkg::CMD_PAUSE: begin
        if (state_i.mode == bmjs_pkg::MODE_RUNNING) begin
          ns.mode    = bmjs_pkg::MODE_PAUSED;
          ns.low_cnt = '0;
        end
      end
      bmjs_pkg::CMD_RESUME: begin
        if (state_i.mode == bmjs_pkg::MODE_PAUSED) begin
          ns.mode    = bmjs_pkg::MODE_RUNNING;
          ns.low_cnt = '0;
        end else if (state_i.jam) begin
          ns.jam     = 1'b0;
          ns.mode    = bmjs_pkg::MODE_RUNNING;
          ns.low_cnt = '0;
        end
      end
      bmjs_pkg::CMD_RESET: begin
        // uptime and since-sort counters keep running
        ns.mode         = bmjs_pkg::MODE_STOPPED;
        ns.speed        = '0;
        ns.low_cnt      = '0;
        ns.jam          = 1'b0;
        ns.gate         = 1'b0;
        ns.seen_color   = '0;
        ns.sorted_color = '0;
      end
      bmjs_pkg::CMD_SIGHT: begin
        ns.seen_color = item_i.color_code;
        ns.gate       = item_i.near_gate;
      end
      bmjs_pkg::CMD_SPEED: begin
        ns.speed = item_i.speed_sample;
      end
      bmjs_pkg::CMD_TICK: begin
      end
      default: begin
      end
    endcase

    // Drive enable as it stands before the tick work
    drive = (ns.mode == bmjs_pkg::MODE_RUNNING) && !ns.jam;

    // Tick: counters, jam detection, sorting
    if (item_i.cmd == bmjs_pkg::CMD_TICK) begin
      ns.uptime_cnt     = bmjs_pkg::sat_inc(state_i.uptime_cnt);
      ns.since_sort_cnt = bmjs_pkg::sat_inc(state_i.since_sort_cnt);

      if (drive && (ns.uptime_cnt > cfg_i.holdoff_ticks)) begin
        if ($signed(state_i.speed) < $signed(cfg_i.low_speed_limit)) begin
          ns.low_cnt = bmjs_pkg::sat_inc(state_i.low_cnt);
        end else begin
          ns.low_cnt = '0;
        end
        if (ns.low_cnt > cfg_i.jam_ticks) begin
          ns.jam = 1'b1;
          alert  = 1'b1;
        end
      end else if (state_i.mode != bmjs_pkg::MODE_RUNNING) begin
        ns.low_cnt = '0;
      end

      // Sort when cooled down or the color differs from the last sorted one
      if (ns.mode == bmjs_pkg::MODE_RUNNING && !ns.jam && state_i.gate &&
          state_i.seen_color != '0 &&
          ((ns.since_sort_cnt > cfg_i.cooldown_ticks) ||
           (state_i.seen_color != state_i.sorted_color))) begin
        fire              = 1'b1;
        fire_color        = state_i.seen_color;
        ns.since_sort_cnt = '0;
        ns.sorted_color   = state_i.seen_color;
      end
    end
  end

  assign state_o = ns;

  assign result_o.mode_status  = ns.jam ? bmjs_pkg::STATUS_JAMMED : ns.mode;
  assign result_o.drive_enable = drive;
  assign result_o.sort_fire    = fire;
  assign result_o.sort_color   = fire_color;
  assign result_o.jam_event    = alert;
  assign result_o.low_duration = ns.low_cnt;

endmodule

// ===== sv/belt_mode_jam_sort_controller_top.sv =====
// Conveyor belt supervisor.
// Input channel in_i carries one command item: start, stop, pause, resume,
// reset, object sighting (color code, near-gate flag), speed sample or
// control tick. Every item yields exactly one result item on out_o: belt
// status, drive enable, sort command and color, jam alert and the current
// low-speed tick count.
// Items are registered on entry; the state update runs combinationally
// between the input register and the result register, so each result
// passes both registers before it can be taken; throughput is one item
// per cycle as long as the receiver takes results.
// When the receiver stalls, the result holds in the output register and
// one more item may wait in the input register; in_i.ready drops only
// when both are full.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write them only while no item is in flight; the block does not enforce it.
// Asynchronous reset (rst_ni low) empties both registers, returns the belt
// to stopped with all counters at zero and loads the default thresholds.
module belt_mode_jam_sort_controller_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  bmjs_in_if.sink           in_i,
  bmjs_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);

  logic              in_vld_q;
  bmjs_pkg::item_t   item_q;
  logic              out_vld_q;
  bmjs_pkg::result_t res_q;
  bmjs_pkg::result_t res_d;
  bmjs_pkg::state_t  state_q;
  bmjs_pkg::state_t  state_d;
  bmjs_pkg::cfg_t    cfg_q;
  logic              in_acc;
  logic              advance;

  // Handshake: advance when an item is held and the result register is free or being drained
  assign advance  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_acc   = in_i.valid && in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.cmd          <= bmjs_pkg::cmd_e'(in_i.cmd);
      item_q.speed_sample <= in_i.speed_sample;
      item_q.color_code   <= in_i.color_code;
      item_q.near_gate    <= in_i.near_gate;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_speed_limit <= bmjs_pkg::LOW_SPEED_LIMIT_RST;
      cfg_q.jam_ticks       <= bmjs_pkg::JAM_TICKS_RST;
      cfg_q.holdoff_ticks   <= bmjs_pkg::HOLDOFF_TICKS_RST;
      cfg_q.cooldown_ticks  <= bmjs_pkg::COOLDOWN_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (bmjs_pkg::cfg_idx_e'(cfg_idx_i))
        bmjs_pkg::CFG_LOW_SPEED_LIMIT: cfg_q.low_speed_limit <= cfg_wdata_i;
        bmjs_pkg::CFG_JAM_TICKS:       cfg_q.jam_ticks       <= cfg_wdata_i;
        bmjs_pkg::CFG_HOLDOFF_TICKS:   cfg_q.holdoff_ticks   <= cfg_wdata_i;
        bmjs_pkg::CFG_COOLDOWN_TICKS:  cfg_q.cooldown_ticks  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Item processing
  bmjs_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Belt state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmjs_pkg::STATE_RST;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.mode_status  = res_q.mode_status;
  assign out_o.drive_enable = res_q.drive_enable;
  assign out_o.sort_fire    = res_q.sort_fire;
  assign out_o.sort_color   = res_q.sort_color;
  assign out_o.jam_event    = res_q.jam_event;
  assign out_o.low_duration = res_q.low_duration;

`ifndef SYNTHESIS
  // A declared jam shows as jammed status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.jam_event |-> res_q.mode_status == bmjs_pkg::STATUS_JAMMED)
    else $error("jam alert without jammed status");

  // A sort needs a color and a driven belt, and never coincides with a jam
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.sort_fire |->
      res_q.drive_enable && res_q.sort_color != '0 && !res_q.jam_event)
    else $error("sort fired while belt not driven or without color");

  // Uptime only counts up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.uptime_cnt >= $past(state_q.uptime_cnt))
    else $error("uptime counter went backwards");

  // An empty result register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_i.ready)
    else $error("input stalled with result register empty");

  // State changes only when an item is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without an item");
`endif

endmodule
